@@ rtl/core/rsc_pkg.sv @@
// Shared types and constants for the run-length sprite clip blitter.
`timescale 1ns / 1ps

package rsc_pkg;

   localparam int COORD_BITS = 12;

   localparam logic [2:0] CSR_SURFACE_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_SURFACE_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_X       = 3'd2;
   localparam logic [2:0] CSR_ORIGIN_Y       = 3'd3;
   localparam logic [2:0] CSR_DRAW_MODE      = 3'd4;
   localparam logic [2:0] CSR_SHADE_OFFSET   = 3'd5;
   localparam logic [2:0] CSR_MONO_HUE       = 3'd6;

   localparam logic [1:0] MODE_COPY   = 2'd0;
   localparam logic [1:0] MODE_SHADOW = 2'd1;
   localparam logic [1:0] MODE_SHIFT  = 2'd2;
   localparam logic [1:0] MODE_MONO   = 2'd3;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       sprite_start;
   } rsc_req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [7:0]            pixel_color;
      logic                  darken;
   } rsc_rsp_type;

   typedef struct packed {
      logic [11:0] surface_width;
      logic [11:0] surface_height;
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [1:0]  draw_mode;
      logic [7:0]  shade_offset;
      logic [7:0]  mono_hue;
   } rsc_cfg_type;

endpackage

@@ rtl/core/rle_sprite_clip_blitter.sv @@
// Top level of the run-length sprite clip blitter.
//
//   Port group  Direction  Handshake          Carries
//   req_*       in         req_valid/stall    one sprite byte and its start mark
//   rsp_*       out        rsp_valid/stall    one pixel write: x, y, color, darken
//   csr_*       in         csr_wr_en          register index and write data
//
// One sprite byte per cycle sustained while the response is not stalled; the pixel
// write of a request goes from the input register into the response register. The
// parse state (header, code and literal handling, row/column wrap, clip) is registered.
// Reset restores register defaults and the parser to the header phase.
// A stalled response holds the parse stage; one request still lands in the
// input register behind it.
`timescale 1ns / 1ps

module rle_sprite_clip_blitter import rsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  rsc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsc_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   rsc_cfg_type cfg;

   logic        s1_valid_ff, s1_valid_in;
   rsc_req_type s1_data_ff,  s1_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsc_rsp_type rsp_data_ff,  rsp_data_in;

   logic                  out_free;
   logic                  s1_adv;
   logic                  hit;
   logic [COORD_BITS-1:0] hit_x, hit_y;
   logic [7:0]            color;
   logic                  darken;

   rsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   rsc_parser u_parser (
      .clock (clock),
      .reset (reset),
      .fire  (s1_adv),
      .item  (s1_data_ff),
      .cfg   (cfg),
      .hit   (hit),
      .hit_x (hit_x),
      .hit_y (hit_y)
   );

   rsc_shade u_shade (
      .src_byte (s1_data_ff.stream_byte),
      .cfg      (cfg),
      .color    (color),
      .darken   (darken)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = s1_adv && hit;
         if (s1_adv && hit) begin
            rsp_data_in.pixel_x     = hit_x;
            rsp_data_in.pixel_y     = hit_y;
            rsp_data_in.pixel_color = color;
            rsp_data_in.darken      = darken;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/rsc_csr.sv @@
// Configuration registers of the sprite clip blitter.
`timescale 1ns / 1ps

module rsc_csr import rsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output rsc_cfg_type cfg
);

   rsc_cfg_type cfg_ff;
   rsc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SURFACE_WIDTH:  cfg_in.surface_width  = csr_wdata[11:0];
            CSR_SURFACE_HEIGHT: cfg_in.surface_height = csr_wdata[11:0];
            CSR_ORIGIN_X:       cfg_in.origin_x       = csr_wdata;
            CSR_ORIGIN_Y:       cfg_in.origin_y       = csr_wdata;
            CSR_DRAW_MODE:      cfg_in.draw_mode      = csr_wdata[1:0];
            CSR_SHADE_OFFSET:   cfg_in.shade_offset   = csr_wdata[7:0];
            CSR_MONO_HUE:       cfg_in.mono_hue       = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.surface_width  <= 12'd320;
         cfg_ff.surface_height <= 12'd200;
         cfg_ff.origin_x       <= 16'd0;
         cfg_ff.origin_y       <= 16'd0;
         cfg_ff.draw_mode      <= MODE_COPY;
         cfg_ff.shade_offset   <= 8'd0;
         cfg_ff.mono_hue       <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/rsc_shade.sv @@
// Pixel color transform for copy, shadow, nibble shift and mono modes.
`timescale 1ns / 1ps

module rsc_shade import rsc_pkg::*; (
   input  logic [7:0]  src_byte,
   input  rsc_cfg_type cfg,
   output logic [7:0]  color,
   output logic        darken
);

   logic signed [8:0] low_sum;
   logic [3:0]        low_sat;

   assign low_sum = $signed({5'd0, src_byte[3:0]})
                  + $signed({cfg.shade_offset[7], cfg.shade_offset});

   always_comb begin
      priority if (low_sum < 9'sd0)
         low_sat = 4'd0;
      else if (low_sum > 9'sd15)
         low_sat = 4'hF;
      else
         low_sat = low_sum[3:0];
   end

   always_comb begin
      darken = 1'b0;
      unique case (cfg.draw_mode)
         MODE_COPY:   color = src_byte;
         MODE_SHADOW: begin
            color  = 8'd0;
            darken = 1'b1;
         end
         MODE_SHIFT:  color = {src_byte[7:4], low_sat};
         MODE_MONO:   color = {cfg.mono_hue[7:4], low_sat};
         default:     color = src_byte;
      endcase
   end

endmodule

@@ rtl/core/rsc_parser.sv @@
// Sprite stream parser: header, skip and literal codes, row/column tracking, clipping.
`timescale 1ns / 1ps

module rsc_parser import rsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  rsc_req_type           item,
   input  rsc_cfg_type           cfg,
   output logic                  hit,
   output logic [COORD_BITS-1:0] hit_x,
   output logic [COORD_BITS-1:0] hit_y
);

   localparam logic [2:0] PH_HEAD1 = 3'd0;
   localparam logic [2:0] PH_HEAD2 = 3'd1;
   localparam logic [2:0] PH_CODE  = 3'd2;
   localparam logic [2:0] PH_LIT   = 3'd3;
   localparam logic [2:0] PH_IDLE  = 3'd4;

   logic [2:0]  phase_ff,  phase_in;
   logic [1:0]  hcnt_ff,   hcnt_in;
   logic [23:0] hbytes_ff, hbytes_in;
   logic [15:0] width_ff,  width_in;
   logic [31:0] pleft_ff,  pleft_in;
   logic [15:0] col_ff,    col_in;
   logic [17:0] row_ff,    row_in;
   logic [7:0]  lit_ff,    lit_in;

   logic [2:0]  phase_e;
   logic [1:0]  hcnt_e;
   logic [23:0] hbytes_e;
   logic [7:0]  b;

   logic [15:0] hdr_w, hdr_h;
   logic [31:0] area;
   logic signed [17:0] w_edge, h_edge;
   logic        hdr_miss;

   logic signed [17:0] x_pos;
   logic signed [19:0] y_cur, y_inc;
   logic signed [19:0] sh_s;
   logic signed [17:0] sw_s;
   logic [17:0] row_inc;
   logic [16:0] col_p1, col_skip;
   logic        is_skip;
   logic [7:0]  amount;
   logic [31:0] pleft_sub;

   assign b        = item.stream_byte;
   assign phase_e  = item.sprite_start ? PH_HEAD1 : phase_ff;
   assign hcnt_e   = item.sprite_start ? 2'd0 : hcnt_ff;
   assign hbytes_e = item.sprite_start ? 24'd0 : hbytes_ff;

   assign hdr_w  = hbytes_e[15:0];
   assign hdr_h  = {b, hbytes_e[23:16]};
   assign area   = hdr_w * hdr_h;
   assign w_edge = $signed({{2{cfg.origin_x[15]}}, cfg.origin_x}) + $signed({2'b00, hdr_w});
   assign h_edge = $signed({{2{cfg.origin_y[15]}}, cfg.origin_y}) + $signed({2'b00, hdr_h});
   assign hdr_miss = (w_edge <= 18'sd0)
                  || ($signed(cfg.origin_x) >= $signed({4'd0, cfg.surface_width}))
                  || (h_edge <= 18'sd0)
                  || ($signed(cfg.origin_y) >= $signed({4'd0, cfg.surface_height}))
                  || (hdr_w == 16'd0) || (hdr_h == 16'd0);

   assign row_inc = (row_ff == '1) ? row_ff : row_ff + 18'd1;
   assign x_pos   = $signed({{2{cfg.origin_x[15]}}, cfg.origin_x}) + $signed({2'b00, col_ff});
   assign y_cur   = $signed({{4{cfg.origin_y[15]}}, cfg.origin_y}) + $signed({2'b00, row_ff});
   assign y_inc   = $signed({{4{cfg.origin_y[15]}}, cfg.origin_y}) + $signed({2'b00, row_inc});
   assign sh_s    = $signed({8'd0, cfg.surface_height});
   assign sw_s    = $signed({6'd0, cfg.surface_width});

   assign is_skip   = b[7] && ({9'd0, b[6:0]} <= width_ff);
   assign amount    = is_skip ? {1'b0, b[6:0]} : b;
   assign pleft_sub = ({24'd0, amount} >= pleft_ff) ? 32'd0 : pleft_ff - {24'd0, amount};
   assign col_skip  = {1'b0, col_ff} + {10'd0, b[6:0]};
   assign col_p1    = {1'b0, col_ff} + 17'd1;

   assign hit   = fire && (phase_e == PH_LIT) && (y_cur < sh_s)
               && (x_pos >= 18'sd0) && (x_pos < sw_s) && (y_cur >= 20'sd0);
   assign hit_x = x_pos[COORD_BITS-1:0];
   assign hit_y = y_cur[COORD_BITS-1:0];

   always_comb begin
      phase_in  = phase_ff;
      hcnt_in   = hcnt_ff;
      hbytes_in = hbytes_ff;
      width_in  = width_ff;
      pleft_in  = pleft_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      lit_in    = lit_ff;
      if (fire) begin
         unique case (phase_e)
            PH_HEAD1, PH_HEAD2: begin
               col_in    = 16'd0;
               row_in    = 18'd0;
               lit_in    = 8'd0;
               phase_in  = phase_e;
               hcnt_in   = hcnt_e + 2'd1;
               hbytes_in = hbytes_e;
               unique case (hcnt_e)
                  2'd0:    hbytes_in[7:0]   = b;
                  2'd1:    hbytes_in[15:8]  = b;
                  2'd2:    hbytes_in[23:16] = b;
                  default: hbytes_in = hbytes_e;
               endcase
               if (hcnt_e == 2'd3) begin
                  hcnt_in   = 2'd0;
                  hbytes_in = 24'd0;
                  if (phase_e == PH_HEAD1 && hbytes_e == 24'h000002 && b == 8'd0) begin
                     phase_in = PH_HEAD2;
                  end else begin
                     width_in = hdr_w;
                     pleft_in = area;
                     phase_in = hdr_miss ? PH_IDLE : PH_CODE;
                  end
               end
            end
            PH_CODE: begin
               if (is_skip) begin
                  pleft_in = pleft_sub;
                  if (col_skip >= {1'b0, width_ff}) begin
                     col_in = 16'(col_skip - {1'b0, width_ff});
                     row_in = row_inc;
                  end else begin
                     col_in = col_skip[15:0];
                  end
                  if (pleft_sub == 32'd0) phase_in = PH_IDLE;
               end else if (y_cur >= sh_s) begin
                  phase_in = PH_IDLE;
               end else begin
                  pleft_in = pleft_sub;
                  if (b == 8'd0) begin
                     if (pleft_sub == 32'd0) phase_in = PH_IDLE;
                  end else begin
                     lit_in   = b;
                     phase_in = PH_LIT;
                  end
               end
            end
            PH_LIT: begin
               if (y_cur >= sh_s) begin
                  phase_in = PH_IDLE;
               end else begin
                  lit_in = lit_ff - 8'd1;
                  if (col_p1 >= {1'b0, width_ff}) begin
                     col_in = 16'd0;
                     row_in = row_inc;
                  end else begin
                     col_in = col_p1[15:0];
                  end
                  priority if (col_p1 >= {1'b0, width_ff} && y_inc >= sh_s)
                     phase_in = PH_IDLE;
                  else if (lit_ff == 8'd1)
                     phase_in = (pleft_ff == 32'd0) ? PH_IDLE : PH_CODE;
                  else
                     phase_in = PH_LIT;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEAD1;
         hcnt_ff   <= 2'd0;
         hbytes_ff <= 24'd0;
         width_ff  <= 16'd0;
         pleft_ff  <= 32'd0;
         col_ff    <= 16'd0;
         row_ff    <= 18'd0;
         lit_ff    <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         hcnt_ff   <= hcnt_in;
         hbytes_ff <= hbytes_in;
         width_ff  <= width_in;
         pleft_ff  <= pleft_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         lit_ff    <= lit_in;
      end
   end

endmodule

@@ verif/tb.sv @@
// Testbench for the sprite clip blitter: directed and random sprites against a pixel-write predictor.
`timescale 1ns / 1ps

module tb;
   import rsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int ROW_LIMIT      = 32'h3FFFF;
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef enum logic [2:0] {
      SCAN_PREFIX, SCAN_SIZE, SCAN_CODE, SCAN_RUN, SCAN_DONE
   } scan_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   rsc_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsc_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = CSR_SURFACE_WIDTH;
   logic [15:0] csr_wdata = '0;

   rle_sprite_clip_blitter DUT (.*);

   // register mirror
   int          cfg_surf_w = 320;
   int          cfg_surf_h = 200;
   int          cfg_org_x = 0;
   int          cfg_org_y = 0;
   logic [1:0]  cfg_mode = MODE_COPY;
   int          cfg_shade = 0;
   logic [7:0]  cfg_hue = '0;

   // parser mirror
   scan_phase_type scan_phase = SCAN_PREFIX;
   logic [31:0] hdr_word = '0;
   int          hdr_count = 0;
   int          spr_width = 0;
   int unsigned pix_left = 0;
   int          src_col = 0;
   int          dst_row = 0;
   int          run_left = 0;

   rsc_rsp_type pending_writes[$];
   bit          calm = 1'b0;
   int          mismatches = 0;
   int          bytes_sent = 0;
   int          stuck_cycles = 0;

   initial forever #5 clock = ~clock;

   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 15);

   function automatic void restart_scan();
      scan_phase = SCAN_PREFIX;
      hdr_word = '0;
      hdr_count = 0;
      spr_width = 0;
      pix_left = 0;
      src_col = 0;
      dst_row = 0;
      run_left = 0;
   endfunction

   function automatic logic [3:0] shade_nibble(input logic [7:0] b);
      int v;
      v = int'(b[3:0]) + cfg_shade;
      if (v > 15) v = 15;
      if (v < 0) v = 0;
      return v[3:0];
   endfunction

   function automatic void trace_sprite_byte(input logic [7:0] b, input logic st);
      int          x, y;
      int unsigned k;
      rsc_rsp_type w;
      if (st) restart_scan();
      case (scan_phase)
         SCAN_PREFIX, SCAN_SIZE: begin
            hdr_word = hdr_word | (32'(b) << (8 * (hdr_count & 3)));
            hdr_count++;
            if (hdr_count >= 4) begin
               if (scan_phase == SCAN_PREFIX && hdr_word == 32'h2) begin
                  scan_phase = SCAN_SIZE;
                  hdr_word = '0;
                  hdr_count = 0;
               end else begin
                  spr_width = int'(hdr_word[15:0]);
                  pix_left = 32'(hdr_word[15:0]) * 32'(hdr_word[31:16]);
                  hdr_count = 0;
                  if (int'(hdr_word[15:0]) + cfg_org_x <= 0 || cfg_org_x >= cfg_surf_w ||
                      int'(hdr_word[31:16]) + cfg_org_y <= 0 || cfg_org_y >= cfg_surf_h ||
                      pix_left == 0)
                     scan_phase = SCAN_DONE;
                  else
                     scan_phase = SCAN_CODE;
               end
            end
         end
         SCAN_CODE: begin
            if (b[7] && int'(b) <= 128 + spr_width) begin
               k = 32'(b) - 32'd128;
               pix_left = (k >= pix_left) ? 32'd0 : pix_left - k;
               src_col += k;
               if (src_col >= spr_width) begin
                  src_col -= spr_width;
                  if (dst_row < ROW_LIMIT) dst_row++;
               end
               if (pix_left == 0) scan_phase = SCAN_DONE;
            end else if (cfg_org_y + dst_row >= cfg_surf_h) begin
               scan_phase = SCAN_DONE;
            end else begin
               pix_left = (32'(b) >= pix_left) ? 32'd0 : pix_left - 32'(b);
               if (b == 0) begin
                  if (pix_left == 0) scan_phase = SCAN_DONE;
               end else begin
                  run_left = int'(b);
                  scan_phase = SCAN_RUN;
               end
            end
         end
         SCAN_RUN: begin
            x = cfg_org_x + src_col;
            y = cfg_org_y + dst_row;
            if (y >= cfg_surf_h) begin
               scan_phase = SCAN_DONE;
               return;
            end
            if (x >= 0 && x < cfg_surf_w && y >= 0) begin
               w.pixel_x = x[COORD_BITS-1:0];
               w.pixel_y = y[COORD_BITS-1:0];
               w.darken = 1'b0;
               case (cfg_mode)
                  MODE_COPY: w.pixel_color = b;
                  MODE_SHADOW: begin
                     w.pixel_color = '0;
                     w.darken = 1'b1;
                  end
                  MODE_SHIFT: w.pixel_color = {b[7:4], shade_nibble(b)};
                  MODE_MONO: w.pixel_color = {cfg_hue[7:4], shade_nibble(b)};
               endcase
               pending_writes.push_back(w);
            end
            src_col++;
            if (src_col >= spr_width) begin
               src_col = 0;
               if (dst_row < ROW_LIMIT) dst_row++;
               if (cfg_org_y + dst_row >= cfg_surf_h) begin
                  scan_phase = SCAN_DONE;
                  return;
               end
            end
            run_left = (run_left - 1) & 8'hFF;
            if (run_left == 0) scan_phase = (pix_left == 0) ? SCAN_DONE : SCAN_CODE;
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      rsc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected pixel write x=%0d y=%0d color=%h darken=%b",
                        rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.pixel_color,
                        rsp_data.darken);
         end else begin
            want = pending_writes.pop_front();
            if (rsp_data.pixel_x !== want.pixel_x || rsp_data.pixel_y !== want.pixel_y ||
                rsp_data.pixel_color !== want.pixel_color ||
                rsp_data.darken !== want.darken) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pixel write mismatch: expected x=%0d y=%0d color=%h darken=%b, %s",
                           want.pixel_x, want.pixel_y, want.pixel_color, want.darken,
                           $sformatf("got x=%0d y=%0d color=%h darken=%b",
                                     rsp_data.pixel_x, rsp_data.pixel_y,
                                     rsp_data.pixel_color, rsp_data.darken));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic st);
      while (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{stream_byte: b, sprite_start: st};
      trace_sprite_byte(b, st);
      bytes_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_writes.size() != 0) @(posedge clock);
   endtask

   task automatic drain();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves the write enable high; the caller lowers it after the last write
   task automatic write_csr(input logic [2:0] idx, input logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_SURFACE_WIDTH:  cfg_surf_w = int'(val[11:0]);
         CSR_SURFACE_HEIGHT: cfg_surf_h = int'(val[11:0]);
         CSR_ORIGIN_X:       cfg_org_x = int'($signed(val));
         CSR_ORIGIN_Y:       cfg_org_y = int'($signed(val));
         CSR_DRAW_MODE:      cfg_mode = val[1:0];
         CSR_SHADE_OFFSET:   cfg_shade = int'($signed(val[7:0]));
         CSR_MONO_HUE:       cfg_hue = val[7:0];
         default: ;
      endcase
   endtask

   task automatic configure(input int sw, input int sh, input int ox, input int oy,
                            input logic [1:0] mode, input int shade, input logic [7:0] hue);
      drain();
      write_csr(CSR_SURFACE_WIDTH, 16'(sw));
      write_csr(CSR_SURFACE_HEIGHT, 16'(sh));
      write_csr(CSR_ORIGIN_X, 16'(ox));
      write_csr(CSR_ORIGIN_Y, 16'(oy));
      write_csr(CSR_DRAW_MODE, 16'(mode));
      write_csr(CSR_SHADE_OFFSET, 16'(shade));
      write_csr(CSR_MONO_HUE, 16'(hue));
      write_csr(CSR_UNUSED, 16'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_header(input int w, input int h, input bit prefix);
      if (prefix) begin
         send_byte(8'h02, 1'b1);
         repeat (3) send_byte(8'h00, 1'b0);
      end
      send_byte(w[7:0], !prefix);
      send_byte(w[15:8], 1'b0);
      send_byte(h[7:0], 1'b0);
      send_byte(h[15:8], 1'b0);
   endtask

   // skip/literal codes with random content, some overlong or past the pixel count, until budget bytes are spent
   task automatic send_random_body(input int w, input int h, input int budget);
      longint left;
      int     len, k, spent;
      left = longint'(w) * h;
      spent = 0;
      while (left > 0 && spent < budget) begin
         if ($urandom_range(199) == 0) hold_until_drained();
         if ($urandom_range(2) == 0) begin
            k = $urandom_range((w > 127) ? 127 : w);
            send_byte(8'(128 + k), 1'b0);
            left -= k;
            spent++;
         end else begin
            if (w <= 126 && $urandom_range(149) == 0) len = $urandom_range(255, 129 + w);
            else if (left < 100 && $urandom_range(9) == 0) len = int'(left) + $urandom_range(3, 1);
            else len = $urandom_range((left < 6) ? int'(left) : 6);
            send_byte(8'(len), 1'b0);
            repeat (len) send_byte(8'($urandom_range(255)), 1'b0);
            left -= len;
            spent += len + 1;
         end
      end
   endtask

   task automatic send_noise(input int count);
      send_byte(8'($urandom_range(255)), 1'b1);
      repeat (count - 1) send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
   endtask

   task automatic random_configure();
      int sw, sh, ox, oy, shade;
      sw = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 4095 : 1) : $urandom_range(24, 1);
      sh = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 4095 : 1) : $urandom_range(24, 1);
      ox = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 32767 : -32768)
                                    : int'($urandom_range(30)) - 10;
      oy = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 32767 : -32768)
                                    : int'($urandom_range(30)) - 10;
      shade = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 127 : -128)
                                       : int'($urandom_range(32)) - 16;
      configure(sw, sh, ox, oy, 2'($urandom_range(3)), shade, 8'($urandom_range(255)));
   endtask

   // reset register values, prefixed header, copy, zero skip, and a near-prefix header
   task automatic test_prefix_and_copy();
      send_header(3, 2, 1'b1);
      send_byte(8'h03, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h02, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h77, 1'b0);
   endtask

   task automatic blit_pair(input logic [1:0] mode, input int shade, input logic [7:0] hue);
      configure(320, 200, 5, 7, mode, shade, hue);
      send_header(2, 1, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_byte(8'hF1, 1'b0);
   endtask

   task automatic test_draw_modes();
      blit_pair(MODE_COPY, 0, 8'h00);
      blit_pair(MODE_SHADOW, 0, 8'h00);
      blit_pair(MODE_SHIFT, 127, 8'h00);
      blit_pair(MODE_MONO, -128, 8'hFF);
   endtask

   task automatic test_clipping();
      configure(4095, 4095, -1, 4094, MODE_COPY, 0, 8'h00);
      send_header(3, 3, 1'b0);
      send_byte(8'h09, 1'b0);
      repeat (9) send_byte(8'($urandom_range(255)), 1'b0);
      configure(1, 1, 32767, 0, MODE_COPY, 0, 8'h00);
      send_header(2, 2, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h12, 1'b0);
      configure(1, 1, -32768, -32768, MODE_COPY, 0, 8'h00);
      send_header(2, 2, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h34, 1'b0);
      configure(8, 8, 0, 0, MODE_COPY, 0, 8'h00);
      send_header(0, 5, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hAA, 1'b0);
   endtask

   task automatic test_bottom_edge();
      configure(8, 1, 0, 0, MODE_COPY, 0, 8'h00);
      send_header(2, 3, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h33, 1'b0);
      send_header(2, 3, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h44, 1'b0);
      configure(8, 2, 0, -1, MODE_COPY, 0, 8'h00);
      send_header(1, 3, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hBB, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hCC, 1'b0);
   endtask

   task automatic test_restart();
      configure(16, 16, 0, 0, MODE_COPY, 0, 8'h00);
      send_header(4, 4, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h20, 1'b0);
      hold_until_drained();
      send_header(1, 1, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h99, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h05, 1'b1);
      send_byte(8'h00, 1'b0);
      send_header(1, 1, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h66, 1'b0);
   endtask

   task automatic test_random_sprites();
      int stop_at, sprite_no, w, h;
      stop_at = bytes_sent + 450;
      sprite_no = 0;
      while (bytes_sent < stop_at) begin
         calm = (sprite_no >= 6 && sprite_no < 10);
         if ($urandom_range(2) == 0) random_configure();
         if ($urandom_range(7) == 0) begin
            send_noise($urandom_range(30, 8));
         end else begin
            case ($urandom_range(9))
               0: w = $urandom_range(65535);
               1: w = 0;
               default: w = $urandom_range(12, 1);
            endcase
            case ($urandom_range(9))
               0: h = $urandom_range(65535);
               1: h = 0;
               default: h = $urandom_range(8, 1);
            endcase
            send_header(w, h, 1'($urandom_range(1)));
            send_random_body(w, h, $urandom_range(80, 10));
         end
         if ($urandom_range(5) == 0)
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)), 1'b0);
         sprite_no++;
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_prefix_and_copy();
      test_draw_modes();
      test_clipping();
      test_bottom_edge();
      test_restart();
      test_random_sprites();
      drain();
      if (mismatches == 0 && pending_writes.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
